// ----- rtl/core/modexp_pkg.sv -----
// shared constants and handshake structs for the modular exponentiation block
`default_nettype none
package modexp_pkg;

	localparam int WORD_W = 31;
	localparam int EXP_W  = 63;
	localparam int CNT_W  = $clog2(WORD_W);
	localparam int IN_W   = ((WORD_W + EXP_W + 7) / 8) * 8;
	localparam int OUT_W  = ((WORD_W + 7) / 8) * 8;

	localparam logic [WORD_W-1:0] DEFAULT_MODULUS = WORD_W'(1000000007);
	localparam logic [WORD_W-1:0] ONE_WORD        = WORD_W'(1);

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] m;
	} mm_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] res;
	} mm_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/modexp_mulmod.sv -----
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
`default_nettype none
module modexp_mulmod (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire modexp_pkg::mm_req_t req,
	output modexp_pkg::mm_rsp_t    rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [modexp_pkg::CNT_W-1:0]        cnt_q;
	logic [modexp_pkg::WORD_W-1:0]       r_q;
	logic [modexp_pkg::WORD_W-1:0]       x_q;
	logic [modexp_pkg::WORD_W-1:0]       y_q;
	logic [modexp_pkg::WORD_W-1:0]       m_q;

	logic [modexp_pkg::WORD_W:0]         dbl;
	logic [modexp_pkg::WORD_W:0]         dbl_red;
	logic [modexp_pkg::WORD_W:0]         sum;
	logic [modexp_pkg::WORD_W:0]         sum_red;

	// r = (2r + bit*x) mod m, with r, x below m
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum     = dbl_red + (y_q[modexp_pkg::WORD_W-1] ? {1'b0, x_q} : '0);
		sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= modexp_pkg::CNT_W'(modexp_pkg::WORD_W - 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			r_q <= sum_red[modexp_pkg::WORD_W-1:0];
			y_q <= {y_q[modexp_pkg::WORD_W-2:0], 1'b0};
		end else if (req.start) begin
			r_q <= '0;
			x_q <= req.x;
			y_q <= req.y;
			m_q <= req.m;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = r_q;

endmodule
`default_nettype wire

// ----- rtl/core/modular_exponentiation_top.sv -----
// modular exponentiation top level: square-and-multiply sequencer around one modular multiplier
//
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: base[30:0], exponent[93:31], zero pad
//  m_*      | out | m_tvalid/m_tready  | m_tdata: power[30:0], zero pad
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_data: modulus[30:0]
//
// each modular product runs 31 bit steps in the multiplier.
// a zero exponent runs the base reduction only; a modulus below 2 skips the multiplier.
// s_tready is high only while idle; a finished result waits in the output register.
// reset loads the modulus with 1000000007 and drops all valids.
`default_nettype none
module modular_exponentiation_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [modexp_pkg::IN_W-1:0]   s_tdata,  // base, exponent, pad
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [modexp_pkg::OUT_W-1:0]       m_tdata,  // power, pad
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [modexp_pkg::WORD_W-1:0] cfg_data  // modulus
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_STEP,
		ST_MUL,
		ST_SQR,
		ST_OUT
	} state_t;

	state_t                         state_q;
	logic [modexp_pkg::WORD_W-1:0]  mod_q;
	logic [modexp_pkg::WORD_W-1:0]  acc_q;
	logic [modexp_pkg::WORD_W-1:0]  b_q;
	logic [modexp_pkg::EXP_W-1:0]   e_q;
	logic                           m_tvalid_q;
	logic [modexp_pkg::WORD_W-1:0]  power_q;
	logic                           start_q;
	logic [modexp_pkg::WORD_W-1:0]  x_q;
	logic [modexp_pkg::WORD_W-1:0]  y_q;

	modexp_pkg::mm_req_t mm_req;
	modexp_pkg::mm_rsp_t mm_rsp;

	logic                           out_free;

	assign mm_req.start = start_q;
	assign mm_req.x     = x_q;
	assign mm_req.y     = y_q;
	assign mm_req.m     = mod_q;

	modexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = modexp_pkg::OUT_W'(power_q);
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mod_q      <= modexp_pkg::DEFAULT_MODULUS;
			m_tvalid_q <= 1'b0;
			start_q    <= 1'b0;
		end else begin
			// one-cycle pulse whenever a product is launched
			start_q <= ((state_q == ST_IDLE) && s_tvalid
					&& (mod_q >= modexp_pkg::WORD_W'(2)))
				|| ((state_q == ST_STEP) && (e_q != '0))
				|| ((state_q == ST_MUL) && mm_rsp.done
					&& (e_q[modexp_pkg::EXP_W-1:1] != '0));
			m_tvalid_q <= ((state_q == ST_OUT) && out_free) || (m_tvalid_q && !m_tready);
			if (cfg_valid) begin
				mod_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						e_q <= s_tdata[modexp_pkg::WORD_W +: modexp_pkg::EXP_W];
						if (mod_q < modexp_pkg::WORD_W'(2)) begin
							acc_q   <= '0;
							state_q <= ST_OUT;
						end else begin
							// base mod m by horner over the base bits
							x_q     <= modexp_pkg::ONE_WORD;
							y_q     <= s_tdata[modexp_pkg::WORD_W-1:0];
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: begin
					if (mm_rsp.done) begin
						b_q     <= mm_rsp.res;
						acc_q   <= modexp_pkg::ONE_WORD;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (e_q == '0) begin
						state_q <= ST_OUT;
					end else if (e_q[0]) begin
						x_q     <= acc_q;
						y_q     <= b_q;
						state_q <= ST_MUL;
					end else begin
						x_q     <= b_q;
						y_q     <= b_q;
						state_q <= ST_SQR;
					end
				end
				ST_MUL: begin
					if (mm_rsp.done) begin
						acc_q <= mm_rsp.res;
						// no higher bits left: the square would not be used
						if (e_q[modexp_pkg::EXP_W-1:1] == '0) begin
							state_q <= ST_OUT;
						end else begin
							x_q     <= b_q;
							y_q     <= b_q;
							state_q <= ST_SQR;
						end
					end
				end
				ST_SQR: begin
					if (mm_rsp.done) begin
						b_q     <= mm_rsp.res;
						e_q     <= e_q >> 1;
						state_q <= ST_STEP;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						power_q <= acc_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- tb/sv/modular_exponentiation_top_tb.sv -----
// self-checking testbench for the modular exponentiation top level
`default_nettype none
module modular_exponentiation_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_W = modexp_pkg::WORD_W;
	localparam int EXP_W  = modexp_pkg::EXP_W;
	localparam int IN_W   = modexp_pkg::IN_W;
	localparam int OUT_W  = modexp_pkg::OUT_W;
	localparam logic [WORD_W-1:0] DEFAULT_MODULUS = modexp_pkg::DEFAULT_MODULUS;
	localparam logic [WORD_W-1:0] ONE_WORD        = modexp_pkg::ONE_WORD;

	localparam logic [WORD_W-1:0] MAX_WORD = {WORD_W{1'b1}};
	localparam logic [EXP_W-1:0]  MAX_EXP  = {EXP_W{1'b1}};

	// predicts base^exponent mod modulus and holds the powers still owed by the block
	class power_board;
		logic [WORD_W-1:0] modulus;
		logic [WORD_W-1:0] pending_powers [$];
		int errors;
		int checked;

		function new();
			modulus = DEFAULT_MODULUS;
			errors  = 0;
			checked = 0;
		endfunction

		function logic [WORD_W-1:0] predict_power(logic [WORD_W-1:0] base,
				logic [EXP_W-1:0] exponent);
			longint unsigned m;
			longint unsigned b;
			longint unsigned acc;
			int i;
			m = modulus;
			if (m < 2)
				return '0;
			b   = base % m;
			acc = 1;
			// right-to-left scan, products stay below 2^62
			for (i = 0; i < EXP_W; i++) begin
				if (exponent[i])
					acc = (acc * b) % m;
				b = (b * b) % m;
			end
			return acc[WORD_W-1:0];
		endfunction

		function void note_request(logic [WORD_W-1:0] base, logic [EXP_W-1:0] exponent);
			pending_powers.push_back(predict_power(base, exponent));
		endfunction

		function void check_power(logic [OUT_W-1:0] word);
			logic [WORD_W-1:0] want;
			if (pending_powers.size() == 0) begin
				errors++;
				$display("%0t: power %0d arrived with nothing pending", $time,
					word[WORD_W-1:0]);
			end else begin
				want = pending_powers.pop_front();
				checked++;
				if (word[WORD_W-1:0] !== want) begin
					errors++;
					$display("%0t: power mismatch, expected %0d actual %0d", $time, want,
						word[WORD_W-1:0]);
				end
			end
		endfunction

		function int pending();
			return pending_powers.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;   // base, exponent, zero pad
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;   // power, zero pad
	logic              cfg_valid;
	logic              cfg_ready;
	logic [WORD_W-1:0] cfg_data;  // modulus

	power_board board = new();
	bit calm;           // no idling on either side while set
	bit stall_request;  // asks the receiver for one long hold-off
	int requests_sent;

	modular_exponentiation_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic [WORD_W-1:0] base, input logic [EXP_W-1:0] exponent);
		int gap;
		s_tdata  <= {{(IN_W - WORD_W - EXP_W){1'b0}}, exponent, base};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_request(base, exponent);
		requests_sent++;
		if (!calm && $urandom_range(0, 99) < 31) begin
			// mostly short gaps, now and then a long one so the next request lands mid-item
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 600) : $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_powers();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_modulus(input logic [WORD_W-1:0] value);
		wait_for_powers();
		repeat (40) @(posedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.modulus = value;
	endtask

	function automatic logic [EXP_W-1:0] pick_exponent();
		logic [EXP_W-1:0] e;
		int w;
		e = EXP_W'({$urandom, $urandom});
		w = $urandom_range(1, 12);
		// full-width exponents are slow, so only a few of them
		case ($urandom_range(0, 15))
			0:       return e;
			1:       return '0;
			2:       return MAX_EXP >> (EXP_W - w);
			default: return e & (MAX_EXP >> (EXP_W - w));
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_base(logic [WORD_W-1:0] m);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return ONE_WORD;
			2:       return m - ONE_WORD;
			3:       return m;
			4:       return MAX_WORD;
			default: return WORD_W'($urandom);
		endcase
	endfunction

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_power(m_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_request) begin
				stall_request = 1'b0;
				hold_left     = 2000;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 31);
			end
		end
	end

	initial begin : stimulus
		logic [WORD_W-1:0] phase_mod [9];
		int p;
		int n;
		int count;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		calm          = 1'b0;
		stall_request = 1'b0;
		requests_sent = 0;
		phase_mod[0] = WORD_W'(2);
		phase_mod[1] = MAX_WORD;
		phase_mod[2] = '0;
		phase_mod[3] = ONE_WORD;
		phase_mod[4] = WORD_W'(3);
		phase_mod[5] = WORD_W'(65537);
		phase_mod[6] = WORD_W'($urandom_range(2, 32'h7FFF_FFFF));
		phase_mod[7] = WORD_W'($urandom_range(2, 1000));
		phase_mod[8] = DEFAULT_MODULUS;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset modulus, field extremes and the zero exponent
		send_item('0, '0);
		send_item('0, EXP_W'(1));
		send_item(MAX_WORD, EXP_W'(1));
		send_item(MAX_WORD, MAX_EXP);
		send_item(ONE_WORD, MAX_EXP);
		send_item(WORD_W'(2), EXP_W'(1) << (EXP_W - 1));
		send_item(DEFAULT_MODULUS - ONE_WORD, EXP_W'(2));
		send_item(DEFAULT_MODULUS, EXP_W'(5));
		send_item(DEFAULT_MODULUS + ONE_WORD, EXP_W'(3));
		send_item(WORD_W'(123456789), EXP_W'(DEFAULT_MODULUS - 2));
		send_item(WORD_W'(3), (EXP_W'(1) << (EXP_W - 2)) | EXP_W'(1));
		for (n = 0; n < 160; n++)
			send_item(pick_base(board.modulus), pick_exponent());

		for (p = 0; p < 9; p++) begin
			write_modulus(phase_mod[p]);
			calm = (p == 5);
			if (p == 4)
				stall_request = 1'b1;
			if (phase_mod[p] < 2) begin
				// degenerate modulus yields zero for everything
				send_item(MAX_WORD, MAX_EXP);
				send_item('0, '0);
				send_item(WORD_W'(7), '0);
			end else if (phase_mod[p] == MAX_WORD) begin
				send_item(MAX_WORD, MAX_EXP);
				send_item(MAX_WORD - ONE_WORD, MAX_EXP);
			end
			count = (phase_mod[p] < 2) ? 30 : 80;
			for (n = 0; n < count; n++) begin
				if (p == 6 && n == count / 2)
					wait_for_powers();
				send_item(pick_base(board.modulus), pick_exponent());
			end
		end
		calm = 1'b0;

		wait_for_powers();
		repeat (100) @(posedge clk);
		$display("%0d requests sent over 10 modulus settings (reset value, 0, 1, 2, max)",
			requests_sent);
		$display("%0d powers checked, %0d mismatches, %0d still pending",
			board.checked, board.errors, board.pending());
		if (board.errors == 0 && board.pending() == 0)
			$display("modular_exponentiation_top test passed");
		else
			$display("modular_exponentiation_top test failed");
		$finish;
	end

	initial begin : watchdog
		#200ms;
		$display("modular_exponentiation_top test failed");
		$finish;
	end

endmodule
`default_nettype wire

// ----- modular_exponentiation_top.f -----
rtl/core/modexp_pkg.sv
rtl/core/modexp_mulmod.sv
rtl/core/modular_exponentiation_top.sv
tb/sv/modular_exponentiation_top_tb.sv
